[rtl/deq_pkg.sv]
package deq_pkg;

    // queue geometry
    localparam int DEPTH = 16;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;

    // operation codes, same encoding as the kind field
    typedef enum logic [KIND_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_REM_FRONT = 3'd2,
        OP_REM_REAR  = 3'd3,
        OP_LIST      = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_op                op;
        logic [DATA_W-1:0]  value;
    } t_cmd;

    // ring slot at a given offset from the front, offset at most DEPTH
    function automatic logic [PTR_W-1:0] slot_at(input logic [PTR_W-1:0] front,
                                                 input logic [CNT_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(front) + SUM_W'(offset);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return PTR_W'(sum);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == '0) begin
            res = PTR_W'(DEPTH - 1);
        end else begin
            res = ptr - PTR_W'(1);
        end
        return res;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] res;
        if (ptr == PTR_W'(DEPTH - 1)) begin
            res = '0;
        end else begin
            res = ptr + PTR_W'(1);
        end
        return res;
    endfunction

endpackage

[rtl/deq_front.sv]
module deq_front
    import deq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [DATA_W-1:0]   i_value,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd,
    input  logic                i_cmd_pop
);

    t_cmd        r_slot [0:1];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_fill;
    logic [1:0]  n_fill;
    logic        op_known;
    logic        push;

    // unused kind codes are taken and dropped
    assign op_known = i_kind inside {OP_INS_FRONT, OP_INS_REAR, OP_REM_FRONT,
                                     OP_REM_REAR, OP_LIST};
    assign o_ready     = (r_fill != 2'd2);
    assign push        = i_valid && o_ready && op_known;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];

    always_comb begin
        n_fill = r_fill;
        if (push && !i_cmd_pop) begin
            n_fill = r_fill + 2'd1;
        end else if (!push && i_cmd_pop) begin
            n_fill = r_fill - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= '{op: t_op'(i_kind), value: i_value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_fill <= n_fill;
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

endmodule

[rtl/deq_back.sv]
module deq_back
    import deq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [DATA_W-1:0]   o_element,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_last_of_run
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_LIST = 3'b100
    } t_state;

    logic [DATA_W-1:0]  mem [0:DEPTH-1];

    t_state             r_state, n_state;
    logic [PTR_W-1:0]   r_front, n_front;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_out_valid, n_out_valid;
    logic [DATA_W-1:0]  r_out_element, n_out_element;
    t_status            r_out_status, n_out_status;
    logic               r_out_last, n_out_last;
    logic [DATA_W-1:0]  r_rd_data;

    logic               rd_en;
    logic [PTR_W-1:0]   rd_addr;
    logic               wr_en;
    logic [PTR_W-1:0]   wr_addr;
    logic               out_free;
    logic               is_full;
    logic               is_empty;
    logic               list_last;

    assign out_free  = !r_out_valid || i_ready;
    assign is_full   = (r_count == CNT_W'(DEPTH));
    assign is_empty  = (r_count == '0);
    assign list_last = ((r_idx + CNT_W'(1)) == r_count);

    always_comb begin
        n_state       = r_state;
        n_front       = r_front;
        n_count       = r_count;
        n_idx         = r_idx;
        n_out_valid   = r_out_valid;
        n_out_element = r_out_element;
        n_out_status  = r_out_status;
        n_out_last    = r_out_last;
        o_cmd_pop     = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = r_front;
        wr_en         = 1'b0;
        wr_addr       = r_front;

        if (i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && out_free) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_INS_FRONT, OP_INS_REAR: begin
                            n_out_valid   = 1'b1;
                            n_out_element = '0;
                            n_out_last    = 1'b1;
                            if (is_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_out_status = ST_OK;
                                wr_en        = 1'b1;
                                n_count      = r_count + CNT_W'(1);
                                if (i_cmd.op == OP_INS_FRONT) begin
                                    wr_addr = ptr_dec(r_front);
                                    n_front = ptr_dec(r_front);
                                end else begin
                                    wr_addr = slot_at(r_front, r_count);
                                end
                            end
                        end
                        OP_REM_FRONT, OP_REM_REAR: begin
                            if (is_empty) begin
                                n_out_valid   = 1'b1;
                                n_out_element = '0;
                                n_out_status  = ST_EMPTY;
                                n_out_last    = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                n_count = r_count - CNT_W'(1);
                                n_state = S_POP;
                                if (i_cmd.op == OP_REM_FRONT) begin
                                    rd_addr = r_front;
                                    n_front = ptr_inc(r_front);
                                end else begin
                                    rd_addr = slot_at(r_front, r_count - CNT_W'(1));
                                end
                            end
                        end
                        OP_LIST: begin
                            if (is_empty) begin
                                n_out_valid   = 1'b1;
                                n_out_element = '0;
                                n_out_status  = ST_EMPTY;
                                n_out_last    = 1'b1;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_front;
                                n_idx   = '0;
                                n_state = S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                n_out_valid   = 1'b1;
                n_out_element = r_rd_data;
                n_out_status  = ST_OK;
                n_out_last    = 1'b1;
                n_state       = S_IDLE;
            end
            S_LIST: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_element = r_rd_data;
                    n_out_status  = ST_OK;
                    n_out_last    = list_last;
                    if (list_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CNT_W'(1);
                        rd_en   = 1'b1;
                        rd_addr = slot_at(r_front, r_idx + CNT_W'(1));
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_cmd.value;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_element <= n_out_element;
        r_out_status  <= n_out_status;
        r_out_last    <= n_out_last;
    end

    assign o_valid       = r_out_valid;
    assign o_element     = r_out_element;
    assign o_status      = r_out_status;
    assign o_last_of_run = r_out_last;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_pop_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> !r_out_valid)
        else $error("removal result would overwrite a pending result");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && o_cmd_pop && !is_full &&
         (i_cmd.op == OP_INS_FRONT || i_cmd.op == OP_INS_REAR))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the queue");

    a_list_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |=> $stable(r_count) && $stable(r_front))
        else $error("listing changed the queue");
`endif

endmodule

[rtl/double_ended_queue.sv]
// bounded double-ended queue of signed 32-bit values in a DEPTH-entry ring
// an insert or error result passes the command queue and the result register; a removal also
//   passes the registered ring read; a listing gives one entry a cycle while results are taken
// throughput: inserts 1 item per cycle while results are taken; a removal waits on the registered
//   ring read before the next command, and a listing holds the execute side to its last entry
// reset: synchronous active low, empties the queue; ring contents are not cleared
module double_ended_queue
    import deq_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic signed [DATA_W-1:0] i_value,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [DATA_W-1:0] o_element,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_last_of_run
);

    // command handed from the accepting side to the execute side
    logic   cmd_valid;
    t_cmd   cmd;
    logic   cmd_pop;

    // front: takes request transactions, drops unused kind codes and keeps a
    // two-entry command queue so requests keep flowing while a result stalls
    deq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_value     (i_value),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // back: holds the ring, front pointer and count, runs each command and
    // drives the registered result transaction
    deq_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_element     (o_element),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

endmodule

[test/double_ended_queue_test.sv]
`timescale 1ns / 1ps

module double_ended_queue_test
    import deq_pkg::*;
();

    // kind codes that the block drops without a result
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    // only the first few mismatches get a full printout
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic signed [DATA_W-1:0] element;
        t_status                  status;
        logic                     last;
    } t_deq_result;

    // block inputs, all driven to known values from time zero
    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic [KIND_W-1:0]        i_kind  = OP_INS_FRONT;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic signed [DATA_W-1:0] o_element;
    logic [STATUS_W-1:0]      o_status;
    logic                     o_last_of_run;

    // shadow copy of the deque contents
    logic signed [DATA_W-1:0] shadow_ring [DEPTH];
    int unsigned              shadow_front = 0;
    int unsigned              shadow_count = 0;

    // results still owed by the block, oldest first
    t_deq_result pending_results [$];

    int fail_count        = 0;
    int ready_hold_cycles = 0;
    int stall_left        = 0;
    bit idling            = 1'b1;

    double_ended_queue uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_element     (o_element),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    // 8 ns clock, first rising edge at 4 ns
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ring position of the entry at a given distance from the front
    function automatic int unsigned ring_index(input int unsigned offset);
        return (shadow_front + offset) % DEPTH;
    endfunction

    function automatic void owe_result(input logic signed [DATA_W-1:0] element,
                                       input t_status status, input logic last);
        t_deq_result r;
        r.element = element;
        r.status  = status;
        r.last    = last;
        pending_results.push_back(r);
    endfunction

    // apply one accepted transaction to the shadow deque and queue up its results
    function automatic void predict_deque_op(input logic [KIND_W-1:0] kind,
                                             input logic signed [DATA_W-1:0] value);
        int unsigned i;
        case (kind)
            OP_INS_FRONT, OP_INS_REAR: begin
                if (shadow_count >= DEPTH) begin
                    // insert refused, contents untouched
                    owe_result('0, ST_FULL, 1'b1);
                end else begin
                    if (kind == OP_INS_FRONT) begin
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_ring[shadow_front] = value;
                    end else begin
                        // also covers the rear insert into an empty deque
                        shadow_ring[ring_index(shadow_count)] = value;
                    end
                    shadow_count++;
                    owe_result('0, ST_OK, 1'b1);
                end
            end
            OP_REM_FRONT, OP_REM_REAR: begin
                if (shadow_count == 0) begin
                    owe_result('0, ST_EMPTY, 1'b1);
                end else begin
                    if (kind == OP_REM_FRONT) begin
                        owe_result(shadow_ring[shadow_front], ST_OK, 1'b1);
                        shadow_front = (shadow_front + 1) % DEPTH;
                    end else begin
                        owe_result(shadow_ring[ring_index(shadow_count - 1)], ST_OK, 1'b1);
                    end
                    shadow_count--;
                end
            end
            OP_LIST: begin
                if (shadow_count == 0) begin
                    owe_result('0, ST_EMPTY, 1'b1);
                end else begin
                    // front to rear, last flag on the rear entry
                    for (i = 0; i < shadow_count; i++) begin
                        owe_result(shadow_ring[ring_index(i)], ST_OK, i + 1 == shadow_count);
                    end
                end
            end
            default: begin
                // spare kind codes give nothing and change nothing
            end
        endcase
    endfunction

    // result side: check the transaction taken at this edge, then pick next ready
    always @(posedge i_clk) begin
        t_deq_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected result: element %0d status %0d last %0b",
                             $time, o_element, o_status, o_last_of_run);
                end
            end else begin
                want = pending_results.pop_front();
                if (o_element !== want.element || o_status !== want.status ||
                    o_last_of_run !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 $time, want.element, want.status, want.last,
                                 o_element, o_status, o_last_of_run);
                    end
                end
            end
        end

        // long hold-off first, then random stall bursts of random length while idling is on
        if (ready_hold_cycles > 0) begin
            ready_hold_cycles--;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 7) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // offer one transaction, maybe after a random gap, and hold it until taken
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic signed [DATA_W-1:0] value);
        int gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_value <= value;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        predict_deque_op(kind, value);
    endtask

    // sender goes quiet until every owed result has come back
    task automatic wait_until_drained();
        i_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_results.size() != 0);
    endtask

    // full-range values with the extremes showing up often
    function automatic logic signed [DATA_W-1:0] random_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return 32'sh0000_0000;
            3: return 32'shffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // both removals and the listing on an empty deque
    task automatic test_empty_queue();
        send_request(OP_REM_FRONT, random_value());
        send_request(OP_REM_REAR, random_value());
        send_request(OP_LIST, random_value());
        wait_until_drained();
    endtask

    // extreme values at both ends, rear insert into an empty deque first
    task automatic test_extreme_values();
        send_request(OP_INS_REAR, 32'sh8000_0000);
        send_request(OP_INS_FRONT, 32'sh7fff_ffff);
        send_request(OP_INS_REAR, 32'sh0000_0000);
        send_request(OP_INS_FRONT, 32'shffff_ffff);
        send_request(OP_INS_REAR, 32'sh5555_aaaa);
        send_request(OP_LIST, random_value());
        send_request(OP_REM_FRONT, random_value());
        send_request(OP_REM_REAR, random_value());
        send_request(OP_REM_REAR, random_value());
        send_request(OP_REM_FRONT, random_value());
        send_request(OP_REM_FRONT, random_value());
        wait_until_drained();
    endtask

    // spare kind codes must not produce any result
    task automatic test_spare_kinds();
        for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
            send_request(KIND_W'(k), random_value());
        end
        wait_until_drained();
    endtask

    // receiver holds off while inserts keep coming: output backs up, input stalls,
    // and the deque runs into full; then list it and empty it from both ends
    task automatic test_fill_under_backpressure();
        idling = 1'b0;
        ready_hold_cycles = 150;
        repeat (DEPTH + 2) begin
            send_request($urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_REAR, random_value());
        end
        send_request(OP_LIST, random_value());
        for (int n = 0; n <= DEPTH; n++) begin
            send_request(n % 2 ? OP_REM_REAR : OP_REM_FRONT, random_value());
        end
        wait_until_drained();
    endtask

    // random mix; insert_pct steers the fill level toward full or empty
    task automatic test_random_traffic(input int items, input int insert_pct,
                                       input bit with_idling);
        int                sent;
        logic [KIND_W-1:0] kind;
        idling = with_idling;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 19) == 0) begin
                // noise, not counted
                kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
            end else begin
                if ($urandom_range(0, 99) < insert_pct) begin
                    kind = $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_REAR;
                end else if ($urandom_range(0, 7) == 0) begin
                    kind = OP_LIST;
                end else begin
                    kind = $urandom_range(0, 1) ? OP_REM_FRONT : OP_REM_REAR;
                end
                sent++;
            end
            send_request(kind, random_value());
        end
        wait_until_drained();
    endtask

    initial begin
        // reset held from time zero, released once
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_extreme_values();
        test_spare_kinds();
        test_fill_under_backpressure();
        test_random_traffic(30, 70, 1'b1);
        test_random_traffic(15, 50, 1'b0);
        test_random_traffic(30, 30, 1'b1);
        // closing stretch without any idling
        test_random_traffic(25, 50, 1'b0);

        // catch any stray result after the last expected one
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/deq_pkg.sv
rtl/deq_front.sv
rtl/deq_back.sv
rtl/double_ended_queue.sv
test/double_ended_queue_test.sv
